/* rtl/circular_queue_with_search_top_assert.svh */
// Assertion macros for the circular queue with search.
// Included by the top level; needs no package.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Immediate implication in the same cycle, disabled during reset.
`define QS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in this cycle, consequent in the next one.
`define QS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QS_ASSERT(lbl, clk, rst, prop, msg)
`define QS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/qsrch_pkg.sv */
// Shared types, codes and helper functions for the circular queue with search.
// No dependencies; used by qsrch_ram and circular_queue_with_search_top.
package qsrch_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 4;
   localparam int CNT_W  = 5;
   localparam int CAP_W  = 5;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_PEEK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic                      found;
      logic [IDX_W-1:0]          position;
      logic signed [DATA_W-1:0]  front_value;
      logic signed [DATA_W-1:0]  back_value;
      logic [CNT_W-1:0]          count;
      logic                      is_empty;
      logic                      is_full;
   } rsp_type;

   // Zero or oversize capacity means the whole ring.
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      if (cap == '0 || cap > CAP_W'(DEPTH)) begin
         return CNT_W'(DEPTH);
      end
      return CNT_W'(cap);
   endfunction

   // Advance a ring index, wrapping at the effective capacity.
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(i) + CNT_W'(1);
      return (inc >= cap) ? '0 : inc[IDX_W-1:0];
   endfunction

endpackage

/* rtl/qsrch_ram.sv */
// Slot storage for the queue: one write port, one read port with registered data.
// Depends on qsrch_pkg for depth and data width.
module qsrch_ram (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [qsrch_pkg::IDX_W-1:0]           wr_addr,
   input  logic signed [qsrch_pkg::DATA_W-1:0]   wr_data,
   input  logic [qsrch_pkg::IDX_W-1:0]           rd_addr,
   output logic signed [qsrch_pkg::DATA_W-1:0]   rd_data
);

   logic signed [qsrch_pkg::DATA_W-1:0] slots_ff [qsrch_pkg::DEPTH];
   logic signed [qsrch_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slots_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/circular_queue_with_search_top.sv */
// Top level of the circular queue with search: sequencer, pointers and result register.
// Depends on qsrch_pkg, qsrch_ram and circular_queue_with_search_top_assert.svh.
//
//   channel | ports                        | handshake
//   --------+------------------------------+----------------------
//   request | req_valid/req_ready/req_data | valid/ready
//   result  | rsp_valid/rsp_ready/rsp_data | valid/ready
//   csr     | csr_wr_en/csr_wr_data        | write strobe, no wait
//
// One transaction at a time. Push and peek go from acceptance to DONE, then to the result
// register; pop first passes FETCH (one read of the new head). Search passes SCAN, which
// compares m slots (1 up to the fill count) in turn through the single slot read port and
// comparator. A full result register stalls the sequencer before it frees req_ready.
// Reset (synchronous) empties the queue and sets capacity to 16; the slots are not cleared.

`include "circular_queue_with_search_top_assert.svh"

module circular_queue_with_search_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  qsrch_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output qsrch_pkg::rsp_type                 rsp_data,
   input  logic                               csr_wr_en,
   input  logic [qsrch_pkg::CAP_W-1:0]        csr_wr_data
);

   qsrch_pkg::state_type                 state_ff, state_in;
   logic [qsrch_pkg::IDX_W-1:0]          head_ff, head_in;
   logic [qsrch_pkg::IDX_W-1:0]          tail_ff, tail_in;
   logic [qsrch_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [qsrch_pkg::CAP_W-1:0]          cap_ff, cap_in;
   logic signed [qsrch_pkg::DATA_W-1:0]  front_ff, front_in;
   logic signed [qsrch_pkg::DATA_W-1:0]  back_ff, back_in;
   logic signed [qsrch_pkg::DATA_W-1:0]  key_ff, key_in;
   logic [qsrch_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [qsrch_pkg::IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [qsrch_pkg::CNT_W-1:0]          left_ff, left_in;
   qsrch_pkg::status_type                status_ff, status_in;
   logic                                 found_ff, found_in;
   logic [qsrch_pkg::IDX_W-1:0]          pos_ff, pos_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   qsrch_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [qsrch_pkg::CNT_W-1:0]          cap_eff;
   logic [qsrch_pkg::CNT_W-1:0]          cfg_last;
   logic [qsrch_pkg::IDX_W-1:0]          head_next;
   logic [qsrch_pkg::IDX_W-1:0]          tail_next;

   logic                                 wr_en;
   logic [qsrch_pkg::IDX_W-1:0]          rd_addr;
   logic signed [qsrch_pkg::DATA_W-1:0]  rd_data;

   assign cap_eff   = qsrch_pkg::eff_cap(cap_ff);
   assign cfg_last  = qsrch_pkg::eff_cap(csr_wr_data) - qsrch_pkg::CNT_W'(1);
   assign head_next = qsrch_pkg::next_slot(head_ff, cap_eff);
   assign tail_next = qsrch_pkg::next_slot(tail_ff, cap_eff);

   qsrch_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_next),
      .wr_data (req_data.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      left_in      = left_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = head_ff;

      unique case (state_ff)
         qsrch_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            // pop reads the new head straight away
            rd_addr = (req_data.mode == qsrch_pkg::MODE_POP) ? head_next : head_ff;
            if (req_valid) begin
               status_in = qsrch_pkg::STATUS_OK;
               found_in  = 1'b0;
               pos_in    = '0;
               key_in    = req_data.value;
               state_in  = qsrch_pkg::ST_DONE;
               unique case (req_data.mode)
                  qsrch_pkg::MODE_PUSH: begin
                     if (count_ff >= cap_eff) begin
                        status_in = qsrch_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = tail_next;
                        back_in  = req_data.value;
                        count_in = count_ff + qsrch_pkg::CNT_W'(1);
                        if (count_ff == '0) begin
                           front_in = req_data.value;
                        end
                     end
                  end
                  qsrch_pkg::MODE_POP: begin
                     if (count_ff == '0) begin
                        status_in = qsrch_pkg::STATUS_EMPTY;
                     end else begin
                        head_in  = head_next;
                        count_in = count_ff - qsrch_pkg::CNT_W'(1);
                        state_in = qsrch_pkg::ST_FETCH;
                     end
                  end
                  qsrch_pkg::MODE_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = qsrch_pkg::STATUS_EMPTY;
                     end else begin
                        cmp_idx_in = head_ff;
                        idx_in     = head_next;
                        left_in    = count_ff;
                        state_in   = qsrch_pkg::ST_SCAN;
                     end
                  end
                  qsrch_pkg::MODE_PEEK: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         qsrch_pkg::ST_FETCH: begin
            front_in = rd_data;
            state_in = qsrch_pkg::ST_DONE;
         end
         qsrch_pkg::ST_SCAN: begin
            // compare the slot read last cycle, fetch the next one
            rd_addr = idx_ff;
            if (rd_data == key_ff) begin
               found_in = 1'b1;
               pos_in   = cmp_idx_ff;
               state_in = qsrch_pkg::ST_DONE;
            end else if (left_ff == qsrch_pkg::CNT_W'(1)) begin
               state_in = qsrch_pkg::ST_DONE;
            end else begin
               cmp_idx_in = idx_ff;
               idx_in     = qsrch_pkg::next_slot(idx_ff, cap_eff);
               left_in    = left_ff - qsrch_pkg::CNT_W'(1);
            end
         end
         qsrch_pkg::ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.found         = found_ff;
               rsp_in.position      = pos_ff;
               rsp_in.front_value   = (count_ff != '0) ? front_ff : '0;
               rsp_in.back_value    = (count_ff != '0) ? back_ff : '0;
               rsp_in.count         = count_ff;
               rsp_in.is_empty      = (count_ff == '0);
               rsp_in.is_full       = (count_ff == cap_eff);
               state_in             = qsrch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qsrch_pkg::ST_IDLE;
         end
      endcase

      // capacity write empties the ring
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         head_in  = '0;
         tail_in  = cfg_last[qsrch_pkg::IDX_W-1:0];
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qsrch_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= qsrch_pkg::IDX_W'(qsrch_pkg::DEPTH - 1);
         count_ff     <= '0;
         cap_ff       <= qsrch_pkg::CAP_W'(qsrch_pkg::DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff   <= front_in;
      back_ff    <= back_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      left_ff    <= left_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `QS_ASSERT(a_count_in_cap, clock, reset, count_ff <= cap_eff, "fill count above capacity")
   `QS_ASSERT(a_scan_left, clock, reset, (state_ff != qsrch_pkg::ST_SCAN) || (left_ff != '0 && left_ff <= count_ff), "scan count out of range")
   `QS_ASSERT(a_found_ok, clock, reset, !(rsp_valid_ff && rsp_ff.found) || (rsp_ff.status == qsrch_pkg::STATUS_OK && !rsp_ff.is_empty), "match reported on a failed search")
   `QS_ASSERT_NEXT(a_done_load, clock, reset, state_ff == qsrch_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == qsrch_pkg::ST_IDLE, "result not loaded")

endmodule
